// ----- rtl/gn2d_pkg.sv -----
// Package for the 2D gradient noise pipeline: constants, types and helpers.
// Depends on nothing; used by gn2d_hash and gradient_noise_2d_top.
package gn2d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int INT_BITS_DEF  = 32;
    localparam int GRAD_COUNT    = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_SEED = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NORMALIZE  = 1'd1;

    localparam logic [63:0] MIX_M1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2 = 64'h94d049bb133111eb;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [33:0] DIAG_Q32 = 34'd3037000500;

    // gradient selector codes (hash modulo 8)
    typedef enum logic [2:0] {
        GR_PX  = 3'd0,
        GR_NX  = 3'd1,
        GR_PY  = 3'd2,
        GR_NY  = 3'd3,
        GR_PP  = 3'd4,
        GR_NP  = 3'd5,
        GR_PN  = 3'd6,
        GR_NN  = 3'd7
    } grad_sel_t;

endpackage

// ----- rtl/gn2d_hash.sv -----
// Pipelined splitmix64-style mixer, 64-bit products cut into 32-bit partials.
// Depends on gn2d_pkg. Registers s0, p1, s1, p2 and s2 in order; advances on en.
module gn2d_hash (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] din,
    output logic [63:0] dout
);
    import gn2d_pkg::*;

    // low 64 bits of v*M = lo*ml + ((lo*mh + hi*ml) << 32)
    logic [63:0] s0_reg;
    logic [63:0] p1_ll_reg;
    logic [31:0] p1_lh_reg, p1_hl_reg;
    logic [63:0] s1_reg;
    logic [63:0] p2_ll_reg;
    logic [31:0] p2_lh_reg, p2_hl_reg;
    logic [63:0] s2_reg;

    logic [63:0] a_next, m1_next, b_next, m2_next;

    always_comb
    begin
        a_next  = din ^ (din >> 30);
        m1_next = p1_ll_reg + {p1_lh_reg + p1_hl_reg, 32'd0};
        b_next  = s1_reg ^ (s1_reg >> 27);
        m2_next = p2_ll_reg + {p2_lh_reg + p2_hl_reg, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg    <= a_next;
            p1_ll_reg <= {32'd0, s0_reg[31:0]} * {32'd0, MIX_M1[31:0]};
            p1_lh_reg <= s0_reg[31:0] * MIX_M1[63:32];
            p1_hl_reg <= s0_reg[63:32] * MIX_M1[31:0];
            s1_reg    <= m1_next;
            p2_ll_reg <= {32'd0, b_next[31:0]} * {32'd0, MIX_M2[31:0]};
            p2_lh_reg <= b_next[31:0] * MIX_M2[63:32];
            p2_hl_reg <= b_next[63:32] * MIX_M2[31:0];
            s2_reg    <= m2_next;
        end
    end

    assign dout = s2_reg ^ (s2_reg >> 31);

endmodule

// ----- rtl/gradient_noise_2d_top.sv -----
// Top level of the 2D gradient noise pipeline.
// Depends on gn2d_pkg and gn2d_hash.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------
//  in       | in_valid/in_ready  | pos_x, pos_y
//  out      | out_valid/out_ready| noise_value
//  cfg      | cfg_we             | cfg_index, cfg_data
//
// One word per cycle sustained; 22 register stages, set by the floor stage,
// the chain of two mixers, key combine, dot product, two blend steps and the
// saturate and output registers.
// Reset clears all stage valid bits and the configuration registers. The whole pipe
// advances when the output stage is empty or taken, so a stall holds every
// stage in place; in_ready = out_ready or output stage empty.
module gradient_noise_2d_top #(
    parameter int FRACTION_BITS = gn2d_pkg::FRAC_BITS_DEF,
    parameter int INTEGER_BITS  = gn2d_pkg::INT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [INTEGER_BITS+FRACTION_BITS-1:0] pos_x,
    input  logic signed [INTEGER_BITS+FRACTION_BITS-1:0] pos_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [FRACTION_BITS+1:0]        noise_value,
    input  logic                                   cfg_we,
    input  logic [gn2d_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [gn2d_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import gn2d_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int LAT = 22;
    localparam int OW  = F + 2;
    // local width: Q.2F products with headroom
    localparam int MW  = 2 * F + 8;
    // multiplier operand width; every operand stays within it
    localparam int NW  = F + 8;
    localparam logic signed [MW-1:0] HALF = MW'(1) <<< (F - 1);
    localparam logic signed [MW-1:0] ONE  = MW'(1) <<< F;
    localparam logic signed [MW-1:0] DIAG =
        MW'((DIAG_Q32 + (34'd1 << (31 - F))) >> (32 - F));
    // cx delay to meet the row hashes, offset tap at the corner hashes
    localparam int D1  = 5;
    localparam int TH  = 10;
    localparam int FDN = 12;

    // ---------------- configuration registers
    logic [63:0] seed_reg;
    logic        norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            norm_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NOISE_SEED: seed_reg <= cfg_data;
                REG_NORMALIZE:  norm_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control
    logic [LAT-1:0] vld_reg;
    logic           adv;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // rounding helper: Q.2F to Q.F, half up (arithmetic shift floors)
    function automatic logic signed [MW-1:0] rnd(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] s;
        s = v + HALF;
        return s >>> F;
    endfunction

    // narrow signed multiply, product fits the local width
    function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b);
        logic signed [NW-1:0]   an;
        logic signed [NW-1:0]   bn;
        logic signed [2*NW-1:0] p;
        an = NW'(a);
        bn = NW'(b);
        p  = an * bn;
        return MW'(p);
    endfunction

    // ---------------- stage 0: floor and local offsets
    logic [63:0] cx_reg, cy_reg;
    logic [F-1:0] lx0_reg, ly0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg  <= 64'(signed'(pos_x >>> F));
            cy_reg  <= 64'(signed'(pos_y >>> F));
            lx0_reg <= pos_x[F-1:0];
            ly0_reg <= pos_y[F-1:0];
        end
    end

    // ---------------- hashes of row and seed
    logic [63:0] hy0, hy1, hs;
    logic [63:0] cy1;
    assign cy1 = cy_reg + 64'd1;

    gn2d_hash u_hy0 (.clk(clk), .en(adv), .din(cy_reg), .dout(hy0));
    gn2d_hash u_hy1 (.clk(clk), .en(adv), .din(cy1),    .dout(hy1));
    gn2d_hash u_hs  (.clk(clk), .en(adv), .din(seed_reg), .dout(hs));

    // carry cx and offsets alongside in shift registers
    logic [63:0] cxd_reg [D1];
    logic [F-1:0] lxd_reg [TH+1], lyd_reg [TH+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cxd_reg[0] <= cx_reg;
            for (int i = 1; i < D1; i++)
                cxd_reg[i] <= cxd_reg[i-1];
            lxd_reg[0] <= lx0_reg;
            lyd_reg[0] <= ly0_reg;
            for (int i = 1; i < TH + 1; i++)
            begin
                lxd_reg[i] <= lxd_reg[i-1];
                lyd_reg[i] <= lyd_reg[i-1];
            end
        end
    end

    // ---------------- combine: corner keys (stage after row hashes)
    logic [63:0] k_reg [4];
    logic [63:0] cxa;
    assign cxa = cxd_reg[D1-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg[0] <= cxa ^ (hy0 + hs + GOLDEN);
            k_reg[1] <= (cxa + 64'd1) ^ (hy0 + hs + GOLDEN);
            k_reg[2] <= cxa ^ (hy1 + hs + GOLDEN);
            k_reg[3] <= (cxa + 64'd1) ^ (hy1 + hs + GOLDEN);
        end
    end

    // ---------------- corner hashes
    logic [63:0] hc [4];
    for (genvar g = 0; g < 4; g++)
    begin : g_corner
        gn2d_hash u_hc (.clk(clk), .en(adv), .din(k_reg[g]), .dout(hc[g]));
    end

    // hash output corresponds to offsets at delay index 10 (stage 11)

    // ---------------- fade curve, runs in parallel on delayed offsets
    // fade stages use offsets at delay index 0..; results aligned by delay
    logic signed [MW-1:0] ft_reg [2], fa_reg [2], fb_reg [2], fc_reg [2];
    logic signed [MW-1:0] ft2_reg [2], ft3_reg [2], ff_reg [2];
    logic signed [MW-1:0] fd_reg [2][FDN];
    logic signed [MW-1:0] tt [2];
    logic signed [MW-1:0] tb_d [2];

    always_comb
    begin
        tt[0] = MW'(lxd_reg[0]);
        tt[1] = MW'(lyd_reg[0]);
        tb_d[0] = MW'(lxd_reg[1]);
        tb_d[1] = MW'(lyd_reg[1]);
    end

    // f0: a, t2 (index1 stage) ; f1: b ; f2: c,t3 ; f3: f
    logic signed [MW-1:0] tc_d [2];
    always_comb
    begin
        tc_d[0] = MW'(lxd_reg[2]);
        tc_d[1] = MW'(lyd_reg[2]);
    end

    logic signed [MW-1:0] f_clamp [2];
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            f_clamp[j] = rnd(mulq(ft3_reg[j], fc_reg[j]));
            if (f_clamp[j] < 0)
                f_clamp[j] = '0;
            else if (f_clamp[j] > ONE)
                f_clamp[j] = ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 2; j++)
            begin
                // lxd[0] -> a, t2
                fa_reg[j]  <= 6 * tt[j] - 15 * ONE;
                ft2_reg[j] <= rnd(mulq(tt[j], tt[j]));
                // lxd[1] -> b
                fb_reg[j]  <= rnd(mulq(tb_d[j], fa_reg[j])) + 10 * ONE;
                ft_reg[j]  <= ft2_reg[j];
                // lxd[2] -> c, t3
                fc_reg[j]  <= rnd(mulq(tc_d[j], fb_reg[j]));
                ft3_reg[j] <= rnd(mulq(ft_reg[j], tc_d[j]));
                ff_reg[j]  <= f_clamp[j];
                fd_reg[j][0] <= ff_reg[j];
                for (int i = 1; i < FDN; i++)
                    fd_reg[j][i] <= fd_reg[j][i-1];
            end
        end
    end
    // ff_reg sits at stage 5, fd[i] at stage 6+i

    // ---------------- gradient dot products
    logic signed [MW-1:0] ox [4], oy [4];
    always_comb
    begin
        ox[0] = MW'(lxd_reg[TH]);        oy[0] = MW'(lyd_reg[TH]);
        ox[1] = MW'(lxd_reg[TH]) - ONE;  oy[1] = MW'(lyd_reg[TH]);
        ox[2] = MW'(lxd_reg[TH]);        oy[2] = MW'(lyd_reg[TH]) - ONE;
        ox[3] = MW'(lxd_reg[TH]) - ONE;  oy[3] = MW'(lyd_reg[TH]) - ONE;
    end

    // gradient components from the low hash bits
    logic signed [MW-1:0] gx [4], gy [4];
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            case (grad_sel_t'(hc[c][2:0]))
                GR_PX:   begin gx[c] = ONE;   gy[c] = '0;    end
                GR_NX:   begin gx[c] = -ONE;  gy[c] = '0;    end
                GR_PY:   begin gx[c] = '0;    gy[c] = ONE;   end
                GR_NY:   begin gx[c] = '0;    gy[c] = -ONE;  end
                GR_PP:   begin gx[c] = DIAG;  gy[c] = DIAG;  end
                GR_NP:   begin gx[c] = -DIAG; gy[c] = DIAG;  end
                GR_PN:   begin gx[c] = DIAG;  gy[c] = -DIAG; end
                default: begin gx[c] = -DIAG; gy[c] = -DIAG; end
            endcase
        end
    end

    // stage A: gradient products (register), stage B: sum and round
    logic signed [MW-1:0] px_reg [4], py_reg [4];
    logic signed [MW-1:0] dot_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                px_reg[c] <= mulq(gx[c], ox[c]);
                py_reg[c] <= mulq(gy[c], oy[c]);
                dot_reg[c] <= rnd(px_reg[c] + py_reg[c]);
            end
        end
    end
    // dot_reg at stage 13; diff at stage 14 meets fx in fd[0][8]

    // ---------------- blend x: diff, multiply, add
    logic signed [MW-1:0] dif_reg [2], base_reg [2], base2_reg [2];
    logic signed [MW-1:0] prd_reg [2], lx_reg [2];
    logic signed [MW-1:0] fxa, fya;
    assign fxa = fd_reg[0][8];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dif_reg[0]  <= dot_reg[1] - dot_reg[0];
            dif_reg[1]  <= dot_reg[3] - dot_reg[2];
            base_reg[0] <= dot_reg[0];
            base_reg[1] <= dot_reg[2];
            for (int j = 0; j < 2; j++)
            begin
                prd_reg[j]   <= mulq(fxa, dif_reg[j]);
                base2_reg[j] <= base_reg[j];
                lx_reg[j]    <= base2_reg[j] + rnd(prd_reg[j]);
            end
        end
    end
    // lx_reg at stage 16; diff at stage 17 meets fy in fd[1][11]

    // ---------------- blend y
    logic signed [MW-1:0] dy_reg, by_reg, by2_reg, py2_reg, v_reg;
    assign fya = fd_reg[1][11];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dy_reg  <= lx_reg[1] - lx_reg[0];
            by_reg  <= lx_reg[0];
            py2_reg <= mulq(fya, dy_reg);
            by2_reg <= by_reg;
            v_reg   <= by2_reg + rnd(py2_reg);
        end
    end
    // v_reg at stage 19

    // ---------------- saturate and normalize
    logic signed [MW-1:0] sat, nrm;
    logic signed [OW-1:0] res_reg;

    always_comb
    begin
        sat = v_reg;
        if (sat > ONE)
            sat = ONE;
        else if (sat < -ONE)
            sat = -ONE;
        nrm = (sat + ONE + MW'(1)) >>> 1;
        if (nrm > ONE)
            nrm = ONE;
        else if (nrm < 0)
            nrm = '0;
    end

    logic signed [OW-1:0] sat_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_reg <= norm_reg ? OW'(nrm) : OW'(sat);
            res_reg <= sat_reg;
        end
    end

    assign noise_value = res_reg;

    // ---------------- assertions
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (noise_value <= OW'(ONE)) && (noise_value >= -OW'(ONE)))
        else $error("noise out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(noise_value))
        else $error("output changed under stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipe stalled with empty output");

endmodule
